// File: src/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg: shared types and constants of the integer to ASCII formatter
// Holds the format command codes, the controller states, the control and
// status bundles between controller and datapath, and the character mapping.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Format commands carried in the input tuser field.
  typedef enum logic [2:0] {
    CMD_SDEC32 = 3'd0,
    CMD_UDEC32 = 3'd1,
    CMD_SDEC64 = 3'd2,
    CMD_UDEC64 = 3'd3,
    CMD_HEX8   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_e;

  localparam int DecDigits = 20;   // digits of the largest 64-bit value
  localparam int TextMax   = 21;   // a minus and 20 digits, above the longest text of 20 characters
  localparam int HexDigits = 8;
  localparam int BitsPerStep = 4;  // binary bits folded into BCD per cycle
  localparam int StepCntW  = 4;    // counts up to 64 / BitsPerStep steps
  localparam int PtrW      = 5;    // indexes DecDigits digits
  localparam int LenW      = 5;    // holds TextMax

  localparam logic [StepCntW-1:0] Steps32 = StepCntW'(32 / BitsPerStep - 1);
  localparam logic [StepCntW-1:0] Steps64 = StepCntW'(64 / BitsPerStep - 1);

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture a new item from the input beat
    logic step;   // one conversion step
    logic count;  // size the text and set up emission
    logic emit;   // load the next character into the output register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic item_ok;   // input beat has a valid command and nonzero room
    logic is_hex;    // input beat asks for the hex format
    logic conv_done; // the current step is the final one
    logic out_free;  // output register can take a character this cycle
    logic last_char; // the next character emitted is the final one
  } ctrl_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = ChLowA + {4'b0, d} - 8'd10;
    end else begin
      c = ChZero + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// File: src/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: integer to decimal or hex ASCII text
// An item is captured from the input beat, converted in the double dabble
// loop (skipped for hex), sized against the room and sent one character
// per beat through an output register that output stalls can hold; an item
// that produces nothing is consumed in the idle state. The next item is
// accepted once the final character is in the output register.
// Reset is asynchronous and active low; it empties the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int BUFFER_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // [63:0] value, [74:64] room, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] cmd
  // Output stream, one character per beat.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] character
  output logic        m_axis_tlast_o
);
  import itaf_pkg::*;

  // The controller accepts a beat only in its idle state. A beat with an
  // unknown command or with zero room is consumed and produces nothing.
  // Decimal values are converted with a double dabble loop that folds four
  // binary bits into the BCD register per cycle; 32-bit values are placed in
  // the upper half of the shift register so that only eight steps run.
  // After conversion the count state finds the leading digit and sizes the text
  // against the room, and then characters go out one per cycle unless the
  // downstream side stalls, through an output register, so the next beat can be
  // accepted while the final character still waits for the downstream side.

  ctrl_cmd_t ctl_cmd;
  ctrl_sts_t ctl_sts;

  itaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  itaf_dp #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i[63:0]),
    .room_i      (s_axis_tdata_i[74:64]),
    .cmd_ctl_i   (ctl_cmd),
    .sts_o       (ctl_sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: src/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl: sequencing state machine of the formatter
// Walks each item through capture, binary to BCD conversion for decimal
// formats, text sizing and character emission, and drives the input ready.
// ----------------------------------------------------------------------------
module itaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itaf_pkg::ctrl_sts_t sts_i,
  output itaf_pkg::ctrl_cmd_t cmd_o
);
  import itaf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.item_ok) begin
          state_d = sts_i.is_hex ? ST_COUNT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.conv_done) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_char) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV:  cmd_o.step  = 1'b1;
      ST_COUNT: cmd_o.count = 1'b1;
      ST_EMIT:  cmd_o.emit  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/itaf_dp.sv
// ----------------------------------------------------------------------------
// itaf_dp: datapath of the formatter
// Sign handling, four-bit-per-cycle double dabble conversion, leading zero
// detection, character selection and the output register.
// ----------------------------------------------------------------------------
module itaf_dp #(
  parameter int BUFFER_SIZE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          cmd_i,
  input  logic [63:0]         value_i,
  input  logic [10:0]         room_i,
  input  itaf_pkg::ctrl_cmd_t cmd_ctl_i,
  output itaf_pkg::ctrl_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                out_last_o
);
  import itaf_pkg::*;

  localparam logic [16:0] BufLim = 17'(BUFFER_SIZE);

  logic [63:0]                       mag_q, mag_d;
  logic [DecDigits-1:0][3:0]         bcd_q, bcd_d;
  logic [StepCntW-1:0]               cnt_q, cnt_d;
  logic [LenW-1:0]                   rlim_q, rlim_d;
  logic [LenW-1:0]                   rem_q, rem_d;
  logic [PtrW-1:0]                   ptr_q, ptr_d;
  logic                              neg_q, neg_d;
  logic                              hex_q, hex_d;
  logic                              sign_pend_q, sign_pend_d;
  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        char_q, char_d;
  logic                              last_q, last_d;

  logic [10:0]    room_c;
  logic [LenW-1:0] rlim_in;
  logic           cmd_known;
  logic [31:0]    neg32;
  logic [63:0]    neg64;

  // Clamp the room to the buffer size and then to the longest possible text.
  always_comb begin
    room_c = room_i;
    if ({6'b0, room_i} > BufLim) begin
      room_c = BufLim[10:0];
    end
    rlim_in = (room_c > 11'(TextMax)) ? LenW'(TextMax) : room_c[LenW-1:0];
    cmd_known = (cmd_i <= CMD_HEX8);
  end

  assign neg32 = 32'd0 - value_i[31:0];
  assign neg64 = 64'd0 - value_i;

  assign sts_o.item_ok   = cmd_known && (rlim_in != '0);
  assign sts_o.is_hex    = (cmd_i == CMD_HEX8);
  assign sts_o.conv_done = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_char = (rem_q == LenW'(1));

  // Binary to BCD: four double dabble steps per cycle.
  logic [DecDigits-1:0][3:0] dd;
  always_comb begin
    dd = bcd_q;
    for (int b = 0; b < BitsPerStep; b++) begin
      for (int k = 0; k < DecDigits; k++) begin
        if (dd[k] >= 4'd5) begin
          dd[k] = dd[k] + 4'd3;
        end
      end
      dd = {dd[DecDigits-1][2:0], dd[DecDigits-2:0], mag_q[63-b]};
    end
  end

  // Index of the most significant nonzero digit, or of the top hex digit for hex.
  logic [PtrW-1:0] top_idx;
  logic [LenW-1:0] ndig;
  logic [LenW-1:0] txt_len;
  logic [LenW-1:0] emit_n;
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < DecDigits; k++) begin
      if (bcd_q[k] != 4'd0) begin
        top_idx = PtrW'(k);
      end
    end
    if (hex_q) begin
      top_idx = PtrW'(HexDigits - 1);
    end
    ndig    = LenW'(top_idx) + LenW'(1);
    txt_len = ndig + {{(LenW-1){1'b0}}, neg_q};
    emit_n  = (txt_len < rlim_q) ? txt_len : rlim_q;
  end

  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rlim_d      = rlim_q;
    rem_d       = rem_q;
    ptr_d       = ptr_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    sign_pend_d = sign_pend_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_ctl_i.load) begin
      rlim_d = rlim_in;
      bcd_d  = '0;
      neg_d  = 1'b0;
      hex_d  = 1'b0;
      cnt_d  = Steps32;
      mag_d  = {value_i[31:0], 32'b0};
      case (cmd_i)
        CMD_SDEC32: begin
          neg_d = value_i[31];
          if (value_i[31]) begin
            mag_d = {neg32, 32'b0};
          end
        end
        CMD_SDEC64: begin
          neg_d = value_i[63];
          cnt_d = Steps64;
          mag_d = value_i[63] ? neg64 : value_i;
        end
        CMD_UDEC64: begin
          cnt_d = Steps64;
          mag_d = value_i;
        end
        CMD_HEX8: begin
          hex_d = 1'b1;
          bcd_d = {{((DecDigits - HexDigits) * 4){1'b0}}, value_i[31:0]};
        end
        default: ;
      endcase
    end

    if (cmd_ctl_i.step) begin
      bcd_d = dd;
      mag_d = {mag_q[63-BitsPerStep:0], {BitsPerStep{1'b0}}};
      cnt_d = cnt_q - StepCntW'(1);
    end

    if (cmd_ctl_i.count) begin
      rem_d       = emit_n;
      ptr_d       = top_idx;
      sign_pend_d = neg_q;
    end

    if (cmd_ctl_i.emit) begin
      out_valid_d = 1'b1;
      last_d      = (rem_q == LenW'(1));
      rem_d       = rem_q - LenW'(1);
      if (sign_pend_q) begin
        char_d      = ChMinus;
        sign_pend_d = 1'b0;
      end else begin
        char_d = digit_char(bcd_q[ptr_q]);
        ptr_d  = ptr_q - PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    bcd_q       <= bcd_d;
    cnt_q       <= cnt_d;
    rlim_q      <= rlim_d;
    rem_q       <= rem_d;
    ptr_q       <= ptr_d;
    neg_q       <= neg_d;
    hex_q       <= hex_d;
    sign_pend_q <= sign_pend_d;
    char_q      <= char_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule
